>>> src/idiv_pkg.sv
package idiv_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int FIELD_W    = 64;
    localparam int REQ_W      = 2;

    typedef logic [REQ_W-1:0]      t_req;
    typedef logic [FIELD_W-1:0]    t_field;
    typedef logic [DATA_WIDTH-1:0] t_word;

    localparam t_req REQ_SQUO = 2'd0;
    localparam t_req REQ_SREM = 2'd1;
    localparam t_req REQ_UQUO = 2'd2;
    localparam t_req REQ_UREM = 2'd3;

    typedef struct packed {
        logic is_rem;
        logic neg;
        logic dzero;
    } t_ctl;

    // one division stage: partial remainder, dividend bits shifting out
    // while quotient bits shift in, divisor magnitude
    typedef struct packed {
        t_ctl  ctl;
        t_word rem;
        t_word quo;
        t_word dvs;
    } t_stage;

endpackage

>>> src/idiv_pre.sv
module idiv_pre (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  idiv_pkg::t_req    i_req_type,
    input  idiv_pkg::t_field  i_dividend,
    input  idiv_pkg::t_field  i_divisor,
    output logic              o_vld,
    output idiv_pkg::t_stage  o_stage
);
    import idiv_pkg::*;

    t_word  w_n;
    t_word  w_d;
    logic   w_signed;
    logic   w_is_rem;
    logic   w_n_neg;
    logic   w_d_neg;
    t_stage n_stage;
    t_stage r_stage;
    logic   r_vld;

    assign w_n = i_dividend[DATA_WIDTH-1:0];
    assign w_d = i_divisor[DATA_WIDTH-1:0];

    always_comb begin
        unique case (i_req_type)
            REQ_SQUO: begin
                w_signed = 1'b1;
                w_is_rem = 1'b0;
            end
            REQ_SREM: begin
                w_signed = 1'b1;
                w_is_rem = 1'b1;
            end
            REQ_UQUO: begin
                w_signed = 1'b0;
                w_is_rem = 1'b0;
            end
            default: begin
                w_signed = 1'b0;
                w_is_rem = 1'b1;
            end
        endcase
    end

    assign w_n_neg = w_signed & w_n[DATA_WIDTH-1];
    assign w_d_neg = w_signed & w_d[DATA_WIDTH-1];

    always_comb begin
        n_stage.ctl.is_rem = w_is_rem;
        // remainder follows the dividend sign, quotient the sign product
        n_stage.ctl.neg    = w_is_rem ? w_n_neg : (w_n_neg ^ w_d_neg);
        n_stage.ctl.dzero  = (w_d == '0);
        n_stage.rem        = '0;
        n_stage.quo        = w_n_neg ? t_word'(~w_n + 1'b1) : w_n;
        n_stage.dvs        = w_d_neg ? t_word'(~w_d + 1'b1) : w_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_vld   = r_vld;
    assign o_stage = r_stage;

endmodule

>>> src/idiv_step.sv
module idiv_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  idiv_pkg::t_stage  i_stage,
    output logic              o_vld,
    output idiv_pkg::t_stage  o_stage
);
    import idiv_pkg::*;

    logic [DATA_WIDTH+1:0] w_diff;
    logic                  w_sub_ok;
    t_stage                n_stage;
    t_stage                r_stage;
    logic                  r_vld;

    // shifted partial remainder is one bit wider than the divisor
    assign w_diff = {1'b0, i_stage.rem, i_stage.quo[DATA_WIDTH-1]}
                  - {2'b00, i_stage.dvs};
    assign w_sub_ok = ~w_diff[DATA_WIDTH+1];

    always_comb begin
        n_stage     = i_stage;
        n_stage.rem = w_sub_ok ? w_diff[DATA_WIDTH-1:0]
                               : {i_stage.rem[DATA_WIDTH-2:0], i_stage.quo[DATA_WIDTH-1]};
        n_stage.quo = {i_stage.quo[DATA_WIDTH-2:0], w_sub_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_vld   = r_vld;
    assign o_stage = r_stage;

endmodule

>>> src/idiv_post.sv
module idiv_post (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  idiv_pkg::t_stage  i_stage,
    output logic              o_vld,
    output idiv_pkg::t_field  o_result
);
    import idiv_pkg::*;

    t_word  w_val;
    t_word  w_fix;
    t_field r_result;
    logic   r_vld;

    // zero divisor: quotient bits come out all ones, remainder forced to zero
    assign w_val = i_stage.ctl.is_rem ? (i_stage.ctl.dzero ? '0 : i_stage.rem)
                                      : i_stage.quo;
    assign w_fix = i_stage.ctl.neg ? t_word'(~w_val + 1'b1) : w_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= t_field'(w_fix);
        end
    end

    assign o_vld    = r_vld;
    assign o_result = r_result;

endmodule

>>> src/idiv_skid.sv
module idiv_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  idiv_pkg::t_field  i_result,
    input  logic              i_stall,
    output logic              o_en,
    output logic              o_valid,
    output idiv_pkg::t_field  o_result
);
    import idiv_pkg::*;

    logic   r_skid_v;
    t_field r_skid;

    // the pipeline keeps moving until the skid register holds a result
    assign o_en     = ~r_skid_v;
    assign o_valid  = r_skid_v | i_vld;
    assign o_result = r_skid_v ? r_skid : i_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (!i_stall) begin
                r_skid_v <= 1'b0;
            end
        end else if (i_vld && i_stall) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v && i_vld && i_stall) begin
            r_skid <= i_result;
        end
    end

endmodule

>>> src/int64_divider.sv
// channel   direction  handshake          payload
// request   in         i_valid / o_stall  i_req_type, i_dividend, i_divisor
// result    out        o_valid / i_stall  o_result
//
// one request accepted per cycle while o_stall is low; the pipeline is made of
// one operand stage, one restoring step per quotient bit, one sign stage
// the skid register at the output holds a stalled result and freezes the pipeline while it is occupied
// o_stall comes from a register: it rises once a result waits in the skid slot
// reset clears all valid bits; data registers are not reset
module int64_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  idiv_pkg::t_req    i_req_type,
    input  idiv_pkg::t_field  i_dividend,
    input  idiv_pkg::t_field  i_divisor,
    output logic              o_valid,
    input  logic              i_stall,
    output idiv_pkg::t_field  o_result
);
    import idiv_pkg::*;

    logic                w_en;
    logic [DATA_WIDTH:0] w_vld;
    t_stage              w_stage [DATA_WIDTH+1];
    logic                w_post_vld;
    t_field              w_post_result;

    assign o_stall = ~w_en;

    idiv_pre u_pre (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_vld      (i_valid),
        .i_req_type (i_req_type),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_vld      (w_vld[0]),
        .o_stage    (w_stage[0])
    );

    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_step
        idiv_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[g]),
            .i_stage (w_stage[g]),
            .o_vld   (w_vld[g+1]),
            .o_stage (w_stage[g+1])
        );
    end

    idiv_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (w_vld[DATA_WIDTH]),
        .i_stage  (w_stage[DATA_WIDTH]),
        .o_vld    (w_post_vld),
        .o_result (w_post_result)
    );

    idiv_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_post_vld),
        .i_result (w_post_result),
        .i_stall  (i_stall),
        .o_en     (w_en),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    a_frozen_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> ($stable(w_vld) && $stable(w_post_vld)))
        else $error("pipeline valid bits moved while stalled");

    a_skid_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_post_vld && i_stall && !o_stall) |=> o_stall)
        else $error("stalled result not captured in skid register");

    a_skid_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stall && !i_stall) |=> !o_stall)
        else $error("skid register not released after result taken");

endmodule

>>> verif/tb_int64_divider.sv
`timescale 1ns / 1ps

module tb_int64_divider;
    import idiv_pkg::*;

    localparam int     TAIL_CYCLES = 100;
    localparam t_field ALL_ONES    = '1;
    localparam t_field MIN_VAL     = 64'h8000_0000_0000_0000;
    localparam t_field MAX_VAL     = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        t_req   op;
        t_field dividend;
        t_field divisor;
        t_field result;
    } t_division;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_stall;
    t_req   i_req_type;
    t_field i_dividend;
    t_field i_divisor;
    logic   o_valid;
    logic   i_stall;
    t_field o_result;

    t_division pending_results[$];
    t_division oldest;
    int        n_requests   = 0;
    int        n_results    = 0;
    int        n_mismatches = 0;
    int        sender_idle_pct = 0;
    int        stall_pct       = 0;

    int64_divider dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[int64_divider] ERROR");
        $finish;
    end

    // result-side back pressure
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic t_field quotient_or_remainder(t_req op, t_field dividend,
                                                     t_field divisor);
        logic   signed_op;
        logic   dividend_neg;
        logic   divisor_neg;
        t_field num;
        t_field den;
        t_field quo;
        t_field rem;
        signed_op    = (op == REQ_SQUO) || (op == REQ_SREM);
        dividend_neg = signed_op && dividend[FIELD_W-1];
        divisor_neg  = signed_op && divisor[FIELD_W-1];
        // magnitude of the minimum value wraps to 2^63, still right as unsigned
        num = dividend_neg ? -dividend : dividend;
        den = divisor_neg ? -divisor : divisor;
        // zero divisor: all-ones quotient magnitude, zero remainder
        if (den == '0) begin
            quo = ALL_ONES;
            rem = '0;
        end else begin
            quo = num / den;
            rem = num % den;
        end
        case (op)
            REQ_SQUO: return (dividend_neg != divisor_neg) ? -quo : quo;
            REQ_SREM: return dividend_neg ? -rem : rem;
            REQ_UQUO: return quo;
            default:  return rem;
        endcase
    endfunction

    // mix of corner values, full-width values and shortened values of either sign
    function automatic t_field random_operand();
        t_field v;
        int     pick;
        v    = {$urandom, $urandom};
        pick = $urandom_range(9);
        if (pick == 0) begin
            case ($urandom_range(4))
                0:       v = '0;
                1:       v = 64'd1;
                2:       v = ALL_ONES;
                3:       v = MIN_VAL;
                default: v = MAX_VAL;
            endcase
        end else if (pick > 2) begin
            v = v >> $urandom_range(63);
            if ($urandom_range(1) == 1)
                v = -v;
        end
        return v;
    endfunction

    task automatic send_request(t_req op, t_field dividend, t_field divisor);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            i_valid    <= 1'b0;
            i_dividend <= {$urandom, $urandom};
        end
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_req_type <= op;
        i_dividend <= dividend;
        i_divisor  <= divisor;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        pending_results.push_back('{op, dividend, divisor,
                                    quotient_or_remainder(op, dividend, divisor)});
        n_requests++;
    endtask

    // sender holds off until every outstanding result is back
    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("o_result %h arrived with no request outstanding", o_result);
                n_mismatches++;
            end else begin
                oldest = pending_results.pop_front();
                n_results++;
                if (o_result !== oldest.result) begin
                    $error("o_result mismatch (op %0d, %h / %h): expected %h actual %h",
                           oldest.op, oldest.dividend, oldest.divisor, oldest.result,
                           o_result);
                    n_mismatches++;
                end
            end
        end
    end

    task automatic test_zero_divisor();
        send_request(REQ_SQUO, 64'd5, '0);
        send_request(REQ_SQUO, -64'd5, '0);
        send_request(REQ_SREM, -64'd5, '0);
        send_request(REQ_UQUO, ALL_ONES, '0);
        send_request(REQ_UREM, 64'd123, '0);
        send_request(REQ_SQUO, MIN_VAL, '0);
    endtask

    task automatic test_minimum_value();
        send_request(REQ_SQUO, MIN_VAL, ALL_ONES);
        send_request(REQ_SREM, MIN_VAL, ALL_ONES);
        send_request(REQ_SQUO, MIN_VAL, 64'd1);
        send_request(REQ_SQUO, MIN_VAL, MIN_VAL);
        send_request(REQ_SREM, MIN_VAL, 64'd3);
        send_request(REQ_SQUO, MAX_VAL, MIN_VAL);
        send_request(REQ_UQUO, MIN_VAL, ALL_ONES);
    endtask

    task automatic test_sign_combinations();
        send_request(REQ_SQUO, 64'd7, -64'd2);
        send_request(REQ_SQUO, -64'd7, 64'd2);
        send_request(REQ_SQUO, -64'd7, -64'd2);
        send_request(REQ_SREM, 64'd7, -64'd2);
        send_request(REQ_SREM, -64'd7, 64'd2);
        send_request(REQ_SREM, -64'd7, -64'd2);
        send_request(REQ_SREM, '0, ALL_ONES);
    endtask

    task automatic test_unsigned_extremes();
        send_request(REQ_UQUO, ALL_ONES, 64'd1);
        send_request(REQ_UQUO, '0, ALL_ONES);
        send_request(REQ_UQUO, ALL_ONES, ALL_ONES);
        send_request(REQ_UREM, ALL_ONES, MIN_VAL);
        send_request(REQ_UREM, MAX_VAL, ALL_ONES);
    endtask

    task automatic test_random_requests(int count, int idle_share, int stall_share);
        sender_idle_pct = idle_share;
        stall_pct       = stall_share;
        repeat (count)
            send_request(t_req'($urandom_range(REQ_UREM, REQ_SQUO)),
                         random_operand(), random_operand());
        wait_for_results();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_req_type = REQ_SQUO;
        i_dividend = '0;
        i_divisor  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_divisor();
        test_minimum_value();
        test_sign_combinations();
        test_unsigned_extremes();
        wait_for_results();

        test_random_requests(135, 0, 0);
        test_random_requests(135, 85, 0);
        test_random_requests(135, 0, 85);
        test_random_requests(135, 26, 26);

        $display("covered %0d requests: zero divisors, minimum value, sign mixes,", n_requests);
        $display("unsigned extremes and random operands under gaps and stalls; %0d checked",
                 n_results);
        if (n_mismatches == 0)
            $display("[int64_divider] OK");
        else
            $display("[int64_divider] ERROR");
        $finish;
    end

endmodule

>>> files.f
src/idiv_pkg.sv
src/idiv_pre.sv
src/idiv_step.sv
src/idiv_post.sv
src/idiv_skid.sv
src/int64_divider.sv
verif/tb_int64_divider.sv
